FILE: rtl/mssd_pkg.sv
// Package for the multiplexed seven-segment serial driver: item types, codes and segment table.
`default_nettype none
package mssd_pkg;

	localparam int NUM_DIGITS_DEF     = 4;
	localparam int BITS_PER_DIGIT_DEF = 9;
	localparam int VALUE_W            = 16;
	// decimal digits needed for a VALUE_W-bit number
	localparam int BCD_DIGITS         = 5;
	localparam int SEG_W              = 8;

	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_POINT   = 2'd1,
		KIND_REFRESH = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [VALUE_W-1:0] value;
		logic [1:0]         digit_index;
		logic               point_on;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0] digit_select;
		logic [3:0] bit_number;
		logic       serial_bit;
		logic       last;
	} seg_item_t;

	// segment pattern, a in bit 7 down to g in bit 1, point in bit 0 left clear
	function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] dig);
		logic [SEG_W-1:0] c;
		case (dig)
			4'd0:    c = 8'b11111100;
			4'd1:    c = 8'b01100000;
			4'd2:    c = 8'b11011010;
			4'd3:    c = 8'b11110010;
			4'd4:    c = 8'b01100110;
			4'd5:    c = 8'b10110110;
			4'd6:    c = 8'b10111110;
			4'd7:    c = 8'b11100000;
			4'd8:    c = 8'b11111110;
			4'd9:    c = 8'b11100110;
			default: c = 8'b00000000;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/mux_seven_segment_serial_driver_unit.sv
// Top level of the multiplexed seven-segment serial driver.
//
// Usage:
//   The cmd channel takes one command beat at a time (valid/stall). A write beat
//   converts value to decimal with a shift-and-add-3 converter, one binary bit per
//   cycle, and stores each digit's segment code with its point flag in bit 0; the
//   leading digit keeps its old code when the number needs more digits than the
//   display has. A write holds cmd_stall high until the codes are updated
//   (16 conversion steps, then the code update). A point beat sets or
//   clears one digit's point and is done in the cycle it is taken. A refresh beat
//   sends NUM_DIGITS * BITS_PER_DIGIT beats on the seg channel, digit 0 first,
//   each digit least significant bit first, one beat per cycle from a shift
//   register unless seg_stall holds it; beats are registered on the way out. The
//   stretch of bits past bit 7 is always zero. last marks the final beat.
//   While seg_stall is high the current beat holds and the shift register waits.
//   A new command may be taken while the last refresh beat still waits.
//   Reset clears all codes and points (display blank) and drops seg_valid.
`default_nettype none
module mux_seven_segment_serial_driver_unit
	import mssd_pkg::*;
#(
	parameter int NUM_DIGITS     = NUM_DIGITS_DEF,
	parameter int BITS_PER_DIGIT = BITS_PER_DIGIT_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_item_t cmd,
	output logic           seg_valid,
	input  wire logic      seg_stall,
	output seg_item_t      seg
);

	localparam int DW    = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
	localparam int BW    = $clog2(BITS_PER_DIGIT);
	localparam int CNT_W = $clog2(VALUE_W + 1);
	localparam int BCD_W = 4 * BCD_DIGITS;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CONV  = 3'b010,
		ST_SHIFT = 3'b100
	} state_t;

	state_t                     state_q;
	logic [SEG_W-1:0]           codes_q [NUM_DIGITS];
	logic [NUM_DIGITS-1:0]      points_q;
	logic [VALUE_W-1:0]         bin_q;
	logic [BCD_W-1:0]           bcd_q;
	logic [CNT_W-1:0]           cnt_q;
	logic [DW-1:0]              dig_q;
	logic [BW-1:0]              bit_q;
	logic [BITS_PER_DIGIT-1:0]  shreg_q;
	logic                       seg_valid_q;
	seg_item_t                  seg_q;

	logic                       cmd_take;
	logic                       emit;
	logic                       bit_end;
	logic                       run_end;
	logic [DW-1:0]              nxt_dig;
	logic [BCD_W-1:0]           bcd_adj;
	logic                       lead_ok;
	logic [SEG_W-1:0]           new_code [NUM_DIGITS];

	assign cmd_stall = (state_q != ST_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign seg_valid = seg_valid_q;
	assign seg       = seg_q;

	// one beat leaves the shift register whenever the output slot is free
	assign emit    = (state_q == ST_SHIFT) && (!seg_valid_q || !seg_stall);
	assign bit_end = (bit_q == BW'(BITS_PER_DIGIT - 1));
	assign run_end = bit_end && (dig_q == DW'(NUM_DIGITS - 1));
	assign nxt_dig = (dig_q == DW'(NUM_DIGITS - 1)) ? '0 : dig_q + DW'(1);

	// add 3 to every BCD digit of 5 or more before the next shift
	always_comb begin
		for (int k = 0; k < BCD_DIGITS; k++) begin
			if (bcd_q[4*k +: 4] >= 4'd5) begin
				bcd_adj[4*k +: 4] = bcd_q[4*k +: 4] + 4'd3;
			end else begin
				bcd_adj[4*k +: 4] = bcd_q[4*k +: 4];
			end
		end
	end

	// leading digit is usable only when every decimal digit above it is zero
	always_comb begin
		lead_ok = 1'b1;
		for (int k = 0; k < BCD_DIGITS; k++) begin
			if (k > NUM_DIGITS - 1 && bcd_q[4*k +: 4] != 4'd0) begin
				lead_ok = 1'b0;
			end
		end
	end

	// digit d shows decimal place NUM_DIGITS-1-d; places past the converter read zero
	always_comb begin
		for (int d = 0; d < NUM_DIGITS; d++) begin
			if (NUM_DIGITS - 1 - d < BCD_DIGITS) begin
				new_code[d] = seg_code(bcd_q[4*(NUM_DIGITS-1-d) +: 4]) | SEG_W'(points_q[d]);
			end else begin
				new_code[d] = seg_code(4'd0) | SEG_W'(points_q[d]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			points_q    <= '0;
			cnt_q       <= '0;
			dig_q       <= '0;
			bit_q       <= '0;
			seg_valid_q <= 1'b0;
			for (int d = 0; d < NUM_DIGITS; d++) begin
				codes_q[d] <= '0;
			end
		end else begin
			// output slot: hold while stalled, drop once taken
			if (emit) begin
				seg_valid_q <= 1'b1;
			end else if (!seg_stall) begin
				seg_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						case (kind_t'(cmd.kind))
							KIND_WRITE: begin
								cnt_q   <= '0;
								state_q <= ST_CONV;
							end
							KIND_POINT: begin
								for (int d = 0; d < NUM_DIGITS; d++) begin
									if (d == int'(cmd.digit_index)) begin
										points_q[d]   <= cmd.point_on;
										codes_q[d][0] <= cmd.point_on;
									end
								end
							end
							KIND_REFRESH: begin
								dig_q   <= '0;
								bit_q   <= '0;
								state_q <= ST_SHIFT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_CONV: begin
					if (cnt_q == CNT_W'(VALUE_W)) begin
						for (int d = 0; d < NUM_DIGITS; d++) begin
							if (d != 0 || lead_ok) begin
								codes_q[d] <= new_code[d];
							end
						end
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				ST_SHIFT: begin
					if (emit) begin
						if (bit_end) begin
							bit_q <= '0;
							dig_q <= nxt_dig;
						end else begin
							bit_q <= bit_q + BW'(1);
						end
						if (run_end) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers: converter, shift register and output beat
	always_ff @(posedge clk) begin
		if (cmd_take && kind_t'(cmd.kind) == KIND_WRITE) begin
			bin_q <= cmd.value;
			bcd_q <= '0;
		end else if (state_q == ST_CONV && cnt_q != CNT_W'(VALUE_W)) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[VALUE_W-1]};
			bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
		end

		if (cmd_take && kind_t'(cmd.kind) == KIND_REFRESH) begin
			shreg_q <= BITS_PER_DIGIT'(codes_q[0]);
		end else if (emit) begin
			if (bit_end) begin
				shreg_q <= BITS_PER_DIGIT'(codes_q[nxt_dig]);
			end else begin
				shreg_q <= {1'b0, shreg_q[BITS_PER_DIGIT-1:1]};
			end
		end

		if (emit) begin
			seg_q.digit_select <= 2'(dig_q);
			seg_q.bit_number   <= 4'(bit_q);
			seg_q.serial_bit   <= shreg_q[0];
			seg_q.last         <= run_end;
		end
	end

endmodule
`default_nettype wire

FILE: test/tb_top.sv
// Testbench for the seven-segment serial driver: directed table, random commands, scan checker.
`timescale 1ns / 1ps
module tb_top;
	import mssd_pkg::*;

	localparam int RANDOM_CMDS  = 336;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int SHOW_FAULTS  = 10;
	localparam int PLAN_LEN     = 24;

	// segment patterns for digits 0..9, digit 0 in the low byte
	localparam logic [79:0] GLYPHS = {
		8'hE6, 8'hFE, 8'hE0, 8'hBE, 8'hB6, 8'h66, 8'hF2, 8'hDA, 8'h60, 8'hFC
	};

	// One row of the directed table. Where known is set, shown holds the four
	// digit codes a refresh must scan out, digit 0 in the top byte.
	typedef struct packed {
		kind_t       kind;
		logic [15:0] value;
		logic [1:0]  index;
		logic        lit;
		logic        known;
		logic [31:0] shown;
	} plan_row_t;

	plan_row_t plan [PLAN_LEN] = '{
		'{KIND_REFRESH, 16'h0000, 2'd0, 1'b0, 1'b1, 32'h00000000},
		'{KIND_WRITE,   16'h0000, 2'd0, 1'b0, 1'b0, 32'h0},
		'{KIND_REFRESH, 16'h0000, 2'd0, 1'b0, 1'b1, 32'hFCFCFCFC},
		'{KIND_POINT,   16'h0000, 2'd0, 1'b1, 1'b0, 32'h0},
		'{KIND_POINT,   16'h0000, 2'd3, 1'b1, 1'b0, 32'h0},
		'{KIND_REFRESH, 16'h0000, 2'd0, 1'b0, 1'b1, 32'hFDFCFCFD},
		'{KIND_WRITE,   16'hFFFF, 2'd0, 1'b0, 1'b0, 32'h0},
		'{KIND_REFRESH, 16'h0000, 2'd0, 1'b0, 1'b1, 32'hFDB6F2B7},
		'{KIND_POINT,   16'h0000, 2'd0, 1'b0, 1'b0, 32'h0},
		'{KIND_POINT,   16'h0000, 2'd3, 1'b0, 1'b0, 32'h0},
		'{KIND_WRITE,   16'd9999, 2'd0, 1'b0, 1'b0, 32'h0},
		'{KIND_REFRESH, 16'h0000, 2'd0, 1'b0, 1'b1, 32'hE6E6E6E6},
		'{KIND_WRITE,   16'd10000, 2'd0, 1'b0, 1'b0, 32'h0},
		'{KIND_REFRESH, 16'h0000, 2'd0, 1'b0, 1'b1, 32'hE6FCFCFC},
		'{KIND_NONE,    16'hFFFF, 2'd3, 1'b1, 1'b0, 32'h0},
		'{KIND_REFRESH, 16'h0000, 2'd0, 1'b0, 1'b1, 32'hE6FCFCFC},
		'{KIND_WRITE,   16'd1234, 2'd0, 1'b0, 1'b0, 32'h0},
		'{KIND_POINT,   16'h0000, 2'd1, 1'b1, 1'b0, 32'h0},
		'{KIND_POINT,   16'h0000, 2'd2, 1'b1, 1'b0, 32'h0},
		'{KIND_REFRESH, 16'h0000, 2'd0, 1'b0, 1'b0, 32'h0},
		'{KIND_WRITE,   16'd5678, 2'd0, 1'b0, 1'b0, 32'h0},
		'{KIND_REFRESH, 16'h0000, 2'd0, 1'b0, 1'b0, 32'h0},
		'{KIND_POINT,   16'h0000, 2'd2, 1'b0, 1'b0, 32'h0},
		'{KIND_REFRESH, 16'h0000, 2'd0, 1'b0, 1'b0, 32'h0}
	};

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_stall;
	cmd_item_t cmd;
	logic      seg_valid;
	logic      seg_stall;
	seg_item_t seg;

	// shadow of the display contents
	logic [7:0] digit_codes [NUM_DIGITS_DEF];
	logic       point_lit   [NUM_DIGITS_DEF];

	seg_item_t beats_due [$];

	int  faults;
	int  cycles;
	int  beats_seen;
	int  n_write, n_point, n_refresh, n_ignored;
	bit  calm;       // no idling on either side
	bit  hold_ask;   // one-shot request for the long receiver hold-off

	mux_seven_segment_serial_driver_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.seg_valid (seg_valid),
		.seg_stall (seg_stall),
		.seg       (seg)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Give up on a hung run.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats still due", cycles, beats_due.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [7:0] glyph(input int n);
		return GLYPHS[n*8 +: 8];
	endfunction

	// Queue the full scan of the given codes, digit 0 first, LSB first,
	// with the padding bits past bit 7 held at zero.
	task automatic queue_scan(input logic [31:0] codes);
		seg_item_t b;
		logic [7:0] code;
		for (int d = 0; d < NUM_DIGITS_DEF; d++) begin
			code = codes[(NUM_DIGITS_DEF-1-d)*8 +: 8];
			for (int k = 0; k < BITS_PER_DIGIT_DEF; k++) begin
				b.digit_select = d[1:0];
				b.bit_number   = k[3:0];
				b.serial_bit   = (k < 8) ? code[k] : 1'b0;
				b.last         = (d == NUM_DIGITS_DEF-1) && (k == BITS_PER_DIGIT_DEF-1);
				beats_due.push_back(b);
			end
		end
	endtask

	// Advance the shadow by one accepted command. A refresh queues the scan of
	// the shadow, or of the typed-in codes where the table gives them.
	task automatic track_command(input cmd_item_t c, input logic known,
			input logic [31:0] shown);
		int place;
		int dig;
		logic [31:0] snap;
		case (c.kind)
			KIND_WRITE: begin
				n_write++;
				place = 1;
				for (int d = NUM_DIGITS_DEF-1; d >= 0; d--) begin
					dig = int'(c.value) / place;
					if (d != 0)
						dig = dig % 10;
					// leading digit past 9: keep what it showed
					if (dig < 10)
						digit_codes[d] = glyph(dig) | {7'd0, point_lit[d]};
					place = place * 10;
				end
			end
			KIND_POINT: begin
				n_point++;
				if (int'(c.digit_index) < NUM_DIGITS_DEF) begin
					point_lit[c.digit_index]      = c.point_on;
					digit_codes[c.digit_index][0] = c.point_on;
				end
			end
			KIND_REFRESH: begin
				n_refresh++;
				for (int d = 0; d < NUM_DIGITS_DEF; d++)
					snap[(NUM_DIGITS_DEF-1-d)*8 +: 8] = digit_codes[d];
				queue_scan(known ? shown : snap);
			end
			default: n_ignored++;
		endcase
	endtask

	// Offer one command beat, with random gaps ahead of it, and hold it until taken.
	task automatic send_command(input cmd_item_t c, input logic known,
			input logic [31:0] shown);
		if (!calm) begin
			while ($urandom_range(99) < 33) begin
				cmd_valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do
			@(posedge clk);
		while (cmd_stall !== 1'b0);
		track_command(c, known, shown);
	endtask

	function automatic cmd_item_t random_command();
		cmd_item_t c;
		int pick;
		pick          = $urandom_range(99);
		c.value       = 16'($urandom_range(16'hFFFF));
		c.digit_index = 2'($urandom_range(3));
		c.point_on    = 1'($urandom_range(1));
		if (pick < 30) begin
			c.kind = KIND_REFRESH;
		end else if (pick < 62) begin
			c.kind = KIND_WRITE;
			// mostly numbers that fit, the rest anywhere in range
			if ($urandom_range(3) != 0)
				c.value = 16'($urandom_range(9999));
		end else if (pick < 92) begin
			c.kind = KIND_POINT;
		end else begin
			c.kind = KIND_NONE;
		end
		return c;
	endfunction

	task automatic log_fault(input string what, input seg_item_t want, input seg_item_t got);
		faults++;
		if (faults <= SHOW_FAULTS)
			$display("%s: want sel=%0d bit=%0d data=%0b last=%0b, got sel=%0d bit=%0d data=%0b last=%0b",
				what, want.digit_select, want.bit_number, want.serial_bit, want.last,
				got.digit_select, got.bit_number, got.serial_bit, got.last);
	endtask

	// Receiver: drive seg_stall. Stall at random, drop idling in calm
	// stretches, and hold off for a long stretch once when asked.
	initial begin
		seg_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				for (int h = 0; h < HOLD_CYCLES; h++) begin
					seg_stall <= 1'b1;
					@(posedge clk);
				end
			end
			seg_stall <= calm ? 1'b0 : ($urandom_range(99) < 33);
		end
	end

	// Check every accepted scan beat against the oldest one due.
	always @(posedge clk) begin
		seg_item_t want;
		if (arst_n && seg_valid && !seg_stall) begin
			beats_seen++;
			if (beats_due.size() == 0) begin
				log_fault("beat with none due", seg, seg);
			end else begin
				want = beats_due.pop_front();
				if (seg.digit_select !== want.digit_select || seg.bit_number !== want.bit_number ||
						seg.serial_bit !== want.serial_bit || seg.last !== want.last)
					log_fault("beat mismatch", want, seg);
			end
		end
	end

	initial begin
		cmd_item_t c;
		int sent;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		calm      = 1'b0;
		hold_ask  = 1'b0;
		for (int d = 0; d < NUM_DIGITS_DEF; d++) begin
			digit_codes[d] = 8'h00;
			point_lit[d]   = 1'b0;
		end

		// Hold reset, then release it on an edge.
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table: blank display, extremes, points on the end
		// digits, an oversize leading digit, an unused kind, every glyph.
		for (int r = 0; r < PLAN_LEN; r++) begin
			c.kind        = plan[r].kind;
			c.value       = plan[r].value;
			c.digit_index = plan[r].index;
			c.point_on    = plan[r].lit;
			send_command(c, plan[r].known, plan[r].shown);
		end

		// Random commands, ignored kinds included in the total.
		sent = 0;
		while (sent < RANDOM_CMDS) begin
			calm = (sent >= 60 && sent < 120);
			if (sent == 200 && !hold_ask)
				hold_ask = 1'b1;
			c = random_command();
			send_command(c, 1'b0, 32'h0);
			sent++;
		end
		calm = 1'b0;
		cmd_valid <= 1'b0;

		// Drain the scan beats still due, then let the block settle.
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		faults += beats_due.size();

		$display("covered %0d writes, %0d point changes, %0d refreshes, %0d ignored commands",
			n_write, n_point, n_refresh, n_ignored);
		$display("checked %0d scan beats in %0d cycles, %0d faults", beats_seen, cycles, faults);
		if (faults == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
